// File: design/epg_pkg.sv
// Shared types, register map and reset values for the end-stop pressure guard.
package epg_pkg;

	localparam int unsigned AddrWidth = 5;
	localparam int unsigned DataWidth = 32;

	typedef enum logic [2:0] {
		REG_HARD_CURRENT_LIMIT  = 3'd0,
		REG_STALL_CURRENT_LIMIT = 3'd1,
		REG_NO_MOTION_TIME      = 3'd2,
		REG_MAX_SAMPLE_AGE      = 3'd3,
		REG_MOTION_DELTA        = 3'd4,
		REG_CONFIRM_COUNT       = 3'd5,
		REG_LEG_TIMEOUT         = 3'd6
	} reg_index_t;

	typedef enum logic [1:0] {
		LEG_NONE  = 2'd0,
		LEG_LEFT  = 2'd1,
		LEG_RIGHT = 2'd2
	} leg_code_t;

	localparam logic [15:0] HardCurrentLimitReset  = 16'd20000;
	localparam logic [15:0] StallCurrentLimitReset = 16'd8000;
	localparam logic [15:0] NoMotionTimeReset      = 16'd100;
	localparam logic [15:0] MaxSampleAgeReset      = 16'd250;
	localparam logic [7:0]  MotionDeltaReset       = 8'd2;
	localparam logic [3:0]  ConfirmCountReset      = 4'd2;
	localparam logic [15:0] LegTimeoutReset        = 16'd1000;

	typedef struct packed {
		logic [15:0] hard_current_limit;
		logic [15:0] stall_current_limit;
		logic [15:0] no_motion_time;
		logic [15:0] max_sample_age;
		logic [7:0]  motion_delta;
		logic [3:0]  confirm_count;
		logic [15:0] leg_timeout;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         sweep_leg;
		logic [31:0]        now_ms;
		logic signed [31:0] encoder_count;
		logic               sensor_ack;
		logic               shunt_ok;
		logic               sensor_healthy;
		logic [31:0]        sample_age;
		logic [31:0]        sample_seq;
		logic signed [23:0] motor_current;
	} item_t;

	typedef struct packed {
		logic pressure_detected;
		logic leg_timed_out;
		logic guard_armed;
	} result_t;

endpackage

// File: design/epg_cfg.sv
// APB-style configuration register file of the end-stop pressure guard.
module epg_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [epg_pkg::AddrWidth-1:0]  paddr,
	input  logic [epg_pkg::DataWidth-1:0]  pwdata,
	output logic [epg_pkg::DataWidth-1:0]  prdata,
	output epg_pkg::cfg_t                  cfg
);

	epg_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    reg_sel;

	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[epg_pkg::AddrWidth-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hard_current_limit  <= epg_pkg::HardCurrentLimitReset;
			cfg_q.stall_current_limit <= epg_pkg::StallCurrentLimitReset;
			cfg_q.no_motion_time      <= epg_pkg::NoMotionTimeReset;
			cfg_q.max_sample_age      <= epg_pkg::MaxSampleAgeReset;
			cfg_q.motion_delta        <= epg_pkg::MotionDeltaReset;
			cfg_q.confirm_count       <= epg_pkg::ConfirmCountReset;
			cfg_q.leg_timeout         <= epg_pkg::LegTimeoutReset;
		end else if (wr_en) begin
			unique case (reg_sel)
				epg_pkg::REG_HARD_CURRENT_LIMIT:  cfg_q.hard_current_limit  <= pwdata[15:0];
				epg_pkg::REG_STALL_CURRENT_LIMIT: cfg_q.stall_current_limit <= pwdata[15:0];
				epg_pkg::REG_NO_MOTION_TIME:      cfg_q.no_motion_time      <= pwdata[15:0];
				epg_pkg::REG_MAX_SAMPLE_AGE:      cfg_q.max_sample_age      <= pwdata[15:0];
				epg_pkg::REG_MOTION_DELTA:        cfg_q.motion_delta        <= pwdata[7:0];
				epg_pkg::REG_CONFIRM_COUNT:       cfg_q.confirm_count       <= pwdata[3:0];
				epg_pkg::REG_LEG_TIMEOUT:         cfg_q.leg_timeout         <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			epg_pkg::REG_HARD_CURRENT_LIMIT:  prdata = {16'd0, cfg_q.hard_current_limit};
			epg_pkg::REG_STALL_CURRENT_LIMIT: prdata = {16'd0, cfg_q.stall_current_limit};
			epg_pkg::REG_NO_MOTION_TIME:      prdata = {16'd0, cfg_q.no_motion_time};
			epg_pkg::REG_MAX_SAMPLE_AGE:      prdata = {16'd0, cfg_q.max_sample_age};
			epg_pkg::REG_MOTION_DELTA:        prdata = {24'd0, cfg_q.motion_delta};
			epg_pkg::REG_CONFIRM_COUNT:       prdata = {28'd0, cfg_q.confirm_count};
			epg_pkg::REG_LEG_TIMEOUT:         prdata = {16'd0, cfg_q.leg_timeout};
			default:                          prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: design/epg_core.sv
// Observation state and single-pass pressure, timeout and armed evaluation.
module epg_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  epg_pkg::item_t  item,
	input  epg_pkg::cfg_t   cfg,
	output epg_pkg::result_t result
);

	logic        observing_q, observing_n;
	logic [1:0]  observed_leg_q, observed_leg_n;
	logic [31:0] reference_count_q, reference_count_n;
	logic [31:0] last_motion_time_q, last_motion_time_n;
	logic [31:0] last_seen_seq_q, last_seen_seq_n;
	logic [3:0]  hard_hits_q, hard_hits_n;
	logic [3:0]  stall_hits_q, stall_hits_n;
	logic [31:0] leg_start_time_q, leg_start_time_n;

	logic        leg_valid;
	logic        restart;
	logic [32:0] enc_diff;
	logic [32:0] enc_dist;
	logic        moved;
	logic [31:0] motion_time_mid;
	logic        sample_bad;
	logic        age_ok;
	logic        fresh;
	logic [23:0] cur_mag;
	logic        still;
	logic        over_hard;
	logic        over_stall;
	logic [3:0]  hard_inc;
	logic [3:0]  stall_inc;
	logic [3:0]  stall_mid;
	logic        pressure;
	logic [31:0] leg_elapsed;

	assign leg_valid = (item.sweep_leg == epg_pkg::LEG_LEFT) ||
		(item.sweep_leg == epg_pkg::LEG_RIGHT);
	assign restart = !observing_q || (observed_leg_q != item.sweep_leg);

	// Exact encoder distance in 33 bits, no wrap.
	assign enc_diff = {item.encoder_count[31], item.encoder_count} -
		{reference_count_q[31], reference_count_q};
	assign enc_dist = enc_diff[32] ? (~enc_diff + 33'd1) : enc_diff;
	assign moved = enc_dist >= {25'd0, cfg.motion_delta};
	assign motion_time_mid = moved ? item.now_ms : last_motion_time_q;
	assign stall_mid = moved ? 4'd0 : stall_hits_q;

	assign age_ok = item.sample_age <= {16'd0, cfg.max_sample_age};
	assign sample_bad = !item.sensor_ack || !item.shunt_ok || !age_ok;
	assign fresh = item.sample_seq != last_seen_seq_q;

	assign cur_mag = item.motor_current[23] ? (~item.motor_current + 24'd1) :
		item.motor_current;
	assign still = (item.now_ms - motion_time_mid) >= {16'd0, cfg.no_motion_time};
	assign over_hard = cur_mag >= {8'd0, cfg.hard_current_limit};
	assign over_stall = cur_mag >= {8'd0, cfg.stall_current_limit};

	// Saturate at the confirmation count.
	assign hard_inc = (hard_hits_q < cfg.confirm_count) ? hard_hits_q + 4'd1 : hard_hits_q;
	assign stall_inc = (stall_mid < cfg.confirm_count) ? stall_mid + 4'd1 : stall_mid;

	always_comb begin
		observing_n        = observing_q;
		observed_leg_n     = observed_leg_q;
		reference_count_n  = reference_count_q;
		last_motion_time_n = last_motion_time_q;
		last_seen_seq_n    = last_seen_seq_q;
		hard_hits_n        = hard_hits_q;
		stall_hits_n       = stall_hits_q;
		leg_start_time_n   = leg_start_time_q;
		pressure           = 1'b0;
		if (!leg_valid) begin
			observing_n  = 1'b0;
			hard_hits_n  = 4'd0;
			stall_hits_n = 4'd0;
		end else if (restart) begin
			observing_n        = 1'b1;
			observed_leg_n     = item.sweep_leg;
			reference_count_n  = item.encoder_count;
			last_motion_time_n = item.now_ms;
			last_seen_seq_n    = 32'd0;
			leg_start_time_n   = item.now_ms;
			hard_hits_n        = 4'd0;
			stall_hits_n       = 4'd0;
		end else begin
			if (moved) begin
				reference_count_n  = item.encoder_count;
				last_motion_time_n = item.now_ms;
			end
			stall_hits_n = stall_mid;
			if (sample_bad) begin
				hard_hits_n  = 4'd0;
				stall_hits_n = 4'd0;
			end else if (fresh) begin
				last_seen_seq_n = item.sample_seq;
				if (over_hard) begin
					stall_hits_n = 4'd0;
					hard_hits_n  = hard_inc;
					if (hard_inc >= cfg.confirm_count) begin
						hard_hits_n = 4'd0;
						pressure    = 1'b1;
					end
				end else begin
					hard_hits_n = 4'd0;
					if (still && over_stall) begin
						stall_hits_n = stall_inc;
						if (stall_inc >= cfg.confirm_count) begin
							stall_hits_n = 4'd0;
							pressure     = 1'b1;
						end
					end else begin
						stall_hits_n = 4'd0;
					end
				end
			end
		end
	end

	assign leg_elapsed = item.now_ms - leg_start_time_n;

	always_comb begin
		result.pressure_detected = pressure;
		result.leg_timed_out = !pressure && leg_valid &&
			(leg_elapsed >= {16'd0, cfg.leg_timeout});
		result.guard_armed = item.sensor_ack && item.shunt_ok && age_ok &&
			item.sensor_healthy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			observing_q        <= 1'b0;
			observed_leg_q     <= epg_pkg::LEG_NONE;
			reference_count_q  <= '0;
			last_motion_time_q <= '0;
			last_seen_seq_q    <= '0;
			hard_hits_q        <= '0;
			stall_hits_q       <= '0;
			leg_start_time_q   <= '0;
		end else if (step) begin
			observing_q        <= observing_n;
			observed_leg_q     <= observed_leg_n;
			reference_count_q  <= reference_count_n;
			last_motion_time_q <= last_motion_time_n;
			last_seen_seq_q    <= last_seen_seq_n;
			hard_hits_q        <= hard_hits_n;
			stall_hits_q       <= stall_hits_n;
			leg_start_time_q   <= leg_start_time_n;
		end
	end

endmodule

// File: design/endstop_pressure_guard.sv
// Top level of the end-stop pressure guard: handshake stages, core and registers.
//
// One item per control tick goes in, one result item comes out, in order.
// An item is captured into an input register, evaluated against the
// observation state in one pass of short logic (a few 32-bit subtracts and
// compares), and the result lands in an output register; the observation
// state advances in the same edge the result is written. Throughput is one
// item per clock cycle while result_ready drains the output; an accepted
// item's result moves into the output register once it is free. The input
// and output registers form a two-deep pipe, so an empty input register
// accepts a new item while a finished result still waits for result_ready.
// Configuration registers are written through the APB-style port (pready
// always high) and must only change while the block is idle.
module endstop_pressure_guard (
	input  logic                          clk,
	input  logic                          arst_n,

	// APB-style configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [epg_pkg::AddrWidth-1:0] paddr,
	input  logic [epg_pkg::DataWidth-1:0] pwdata,
	output logic [epg_pkg::DataWidth-1:0] prdata,
	output logic                          pready,

	// Tick item channel
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [1:0]                    sweep_leg,
	input  logic [31:0]                   now_ms,
	input  logic signed [31:0]            encoder_count,
	input  logic                          sensor_ack,
	input  logic                          shunt_ok,
	input  logic                          sensor_healthy,
	input  logic [31:0]                   sample_age,
	input  logic [31:0]                   sample_seq,
	input  logic signed [23:0]            motor_current,

	// Result item channel
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic                          pressure_detected,
	output logic                          leg_timed_out,
	output logic                          guard_armed
);

	epg_pkg::cfg_t    cfg;
	epg_pkg::item_t   item_s1;
	logic             valid_s1;
	epg_pkg::result_t result_core;
	epg_pkg::result_t result_s2;
	logic             valid_s2;
	logic             adv_s2;
	logic             adv_s1;

	assign pready = 1'b1;

	epg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Output register takes a new result when empty or being drained.
	assign adv_s2 = valid_s1 && (!valid_s2 || result_ready);
	// Input register refills when empty or when its item moves on.
	assign adv_s1 = !valid_s1 || adv_s2;
	assign item_ready = adv_s1;

	// Capture the incoming item; payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_valid) begin
			item_s1.sweep_leg      <= sweep_leg;
			item_s1.now_ms         <= now_ms;
			item_s1.encoder_count  <= encoder_count;
			item_s1.sensor_ack     <= sensor_ack;
			item_s1.shunt_ok       <= shunt_ok;
			item_s1.sensor_healthy <= sensor_healthy;
			item_s1.sample_age     <= sample_age;
			item_s1.sample_seq     <= sample_seq;
			item_s1.motor_current  <= motor_current;
		end
	end

	// Evaluate the held item; state advances only when its result is stored.
	epg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s2),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result_core)
	);

	// Hold the result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			result_s2 <= result_core;
		end
	end

	assign result_valid      = valid_s2;
	assign pressure_detected = result_s2.pressure_detected;
	assign leg_timed_out     = result_s2.leg_timed_out;
	assign guard_armed       = result_s2.guard_armed;

endmodule
